FILE: hw/rtl/periodic_task_timer_table_macros.svh
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// same-cycle implication, held off during reset
`define PTT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, held off during reset
`define PTT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// plain implication, checked during reset too
`define PTT_ASSERT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OP_W   = 3;
  localparam int ID_W   = 5;
  localparam int TICK_W = 16;

  localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
  localparam logic [OP_W-1:0] OP_DELAY    = 3'd1;
  localparam logic [OP_W-1:0] OP_SLEEP    = 3'd2;
  localparam logic [OP_W-1:0] OP_WAKEUP   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd5;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd6;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE  = 2'd0;
  localparam mode_t MODE_READY = 2'd1;
  localparam mode_t MODE_SUSP  = 2'd2;
  localparam mode_t MODE_SLEEP = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

FILE: hw/rtl/periodic_task_timer_table.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  op, task_id, tick_count, reload_period
// out      output     out_valid/out_ready  status, result_id, dispatch_valid, last
//
// Register, delay, sleep, wakeup, delete, unknown ops and a schedule with no ready slot
// update state at the accept edge and present their transfer the next cycle.
// Tick and other schedules sweep the countdown/reload memories one slot a cycle through
// a read stage and a write-back stage, returning to idle after the last write-back.
// A dispatch waiting on out_ready holds the sweep; no item is taken during a sweep.
// rst clears the slot modes, the used bits and the sequencer; memories are not cleared.
module periodic_task_timer_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ptt_pkg::OP_W-1:0]    op,
  input  logic [ptt_pkg::ID_W-1:0]    task_id,
  input  logic [ptt_pkg::TICK_W-1:0]  tick_count,
  input  logic [ptt_pkg::TICK_W-1:0]  reload_period,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [ptt_pkg::ID_W-1:0]    result_id,
  output logic                        dispatch_valid,
  output logic                        last
);
  import ptt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [1:0]                      state;
  logic [NUM_SLOTS-1:0]            used;
  logic [NUM_SLOTS-1:0][1:0]       mode;
  logic                            sched_q;
  logic                            rd_active;
  logic [SLOT_W-1:0]               rd_idx;
  logic                            p_valid;
  logic [SLOT_W-1:0]               p_idx;

  logic [COUNT_WIDTH-1:0]          cd_mem [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0]          rl_mem [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0]          cd_q;
  logic [COUNT_WIDTH-1:0]          rl_q;

  logic                            in_fire;
  logic [COUNT_WIDTH-1:0]          cnt_in;
  logic [COUNT_WIDTH-1:0]          per_in;
  logic                            free_found;
  logic [SLOT_W-1:0]               free_idx;
  logic [SLOT_W:0]                 free_id;
  logic                            sel_hit;
  logic [SLOT_W-1:0]               sel_idx;
  logic [NUM_SLOTS-1:0]            ready_vec;
  logic                            more_ready;
  logic                            p_emit;
  logic                            p_susp;
  logic [SLOT_W:0]                 p_id;
  logic [COUNT_WIDTH-1:0]          cd_dec;
  logic                            adv;
  logic                            rd_en;
  logic                            cd_we;
  logic [SLOT_W-1:0]               cd_wa;
  logic [COUNT_WIDTH-1:0]          cd_wd;
  logic                            rl_we;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign cnt_in   = COUNT_WIDTH'(tick_count);
  assign per_in   = COUNT_WIDTH'(reload_period);
  assign free_id  = {1'b0, free_idx} + 1'b1;
  assign p_id     = {1'b0, p_idx} + 1'b1;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!used[j]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(j);
      end
    end
  end

  always_comb begin
    sel_hit = 1'b0;
    sel_idx = '0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (int'(task_id) == j + 1 && used[j]) begin
        sel_hit = 1'b1;
        sel_idx = SLOT_W'(j);
      end
    end
  end

  always_comb begin
    more_ready = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      ready_vec[j] = used[j] && (mode[j] == MODE_READY);
      if (j > int'(p_idx) && ready_vec[j]) more_ready = 1'b1;
    end
  end

  assign p_emit = sched_q && ready_vec[p_idx];
  assign p_susp = !sched_q && used[p_idx] && (mode[p_idx] == MODE_SUSP);
  assign cd_dec = (cd_q == '0) ? '0 : cd_q - 1'b1;
  assign adv    = !(p_valid && p_emit && out_valid && !out_ready);
  assign rd_en  = (state == ST_SCAN) && rd_active && adv;
  assign rl_we  = in_fire && (op == OP_REGISTER) && free_found;

  always_comb begin
    cd_we = 1'b0;
    cd_wa = p_idx;
    cd_wd = cnt_in;
    if (rl_we) begin
      cd_we = 1'b1;
      cd_wa = free_idx;
    end else if (in_fire && (op == OP_DELAY) && sel_hit) begin
      cd_we = 1'b1;
      cd_wa = sel_idx;
    end else if ((state == ST_SCAN) && p_valid && adv) begin
      if (p_emit) begin
        cd_we = 1'b1;
        cd_wd = rl_q;
      end else if (p_susp) begin
        cd_we = 1'b1;
        cd_wd = cd_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cd_we) cd_mem[cd_wa] <= cd_wd;
    if (rl_we) rl_mem[free_idx] <= per_in;
    if (rd_en) begin
      cd_q <= cd_mem[rd_idx];
      rl_q <= rl_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      mode      <= {NUM_SLOTS{MODE_IDLE}};
      out_valid <= 1'b0;
      rd_active <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (in_fire) begin
        out_valid      <= 1'b1;
        status         <= STATUS_OK;
        result_id      <= '0;
        dispatch_valid <= 1'b0;
        last           <= 1'b1;
        case (op)
          OP_REGISTER: begin
            if (free_found) begin
              used[free_idx] <= 1'b1;
              mode[free_idx] <= (cnt_in == '0) ? MODE_READY : MODE_SUSP;
              result_id      <= ID_W'(free_id);
            end else begin
              status <= STATUS_ERR;
            end
          end
          OP_DELAY, OP_SLEEP, OP_WAKEUP, OP_DELETE: begin
            if (!sel_hit) begin
              status <= STATUS_ERR;
            end else begin
              case (op)
                OP_DELAY:  mode[sel_idx] <= MODE_SUSP;
                OP_SLEEP:  mode[sel_idx] <= MODE_SLEEP;
                OP_WAKEUP: mode[sel_idx] <= MODE_READY;
                default: begin
                  used[sel_idx] <= 1'b0;
                  mode[sel_idx] <= MODE_IDLE;
                end
              endcase
            end
          end
          OP_TICK: begin
            state     <= ST_SCAN;
            sched_q   <= 1'b0;
            rd_active <= 1'b1;
            rd_idx    <= '0;
            p_valid   <= 1'b0;
          end
          OP_SCHEDULE: begin
            if (|ready_vec) begin
              out_valid <= 1'b0;
              state     <= ST_SCAN;
              sched_q   <= 1'b1;
              rd_active <= 1'b1;
              rd_idx    <= '0;
              p_valid   <= 1'b0;
            end
          end
          default: status <= STATUS_ERR;
        endcase
      end
      if ((state == ST_SCAN) && adv) begin
        p_valid <= rd_active;
        p_idx   <= rd_idx;
        if (rd_active) begin
          if (rd_idx == SLOT_W'(NUM_SLOTS - 1)) rd_active <= 1'b0;
          else rd_idx <= rd_idx + 1'b1;
        end
        if (p_valid) begin
          if (p_emit) begin
            mode[p_idx]    <= MODE_SUSP;
            out_valid      <= 1'b1;
            status         <= STATUS_OK;
            result_id      <= ID_W'(p_id);
            dispatch_valid <= 1'b1;
            last           <= !more_ready;
          end else if (p_susp && cd_dec == '0) begin
            mode[p_idx] <= MODE_READY;
          end
          if (p_idx == SLOT_W'(NUM_SLOTS - 1)) begin
            state   <= ST_IDLE;
            p_valid <= 1'b0;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ptt_checker.sv
`include "periodic_task_timer_table_macros.svh"

module ptt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        status,
  input logic [ptt_pkg::ID_W-1:0]    result_id,
  input logic                        dispatch_valid,
  input logic                        last
);
  import ptt_pkg::*;

  `PTT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PTT_ASSERT_IMP(a_dispatch_ok, clk, rst, out_valid && dispatch_valid,
                  status == STATUS_OK && result_id != '0)
  `PTT_ASSERT_IMP(a_single_last, clk, rst, out_valid && !dispatch_valid, last)
  `PTT_ASSERT_IMP(a_no_take_mid, clk, rst, out_valid && !last, !in_ready)
  `PTT_ASSERT_ALL(a_reset_empty, clk, $past(rst) && !rst, !out_valid)

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);
